// ===== src/winch_line_velocity_controller_unit_defines.svh =====
// Assertion macros used by the asserting controller module.
`ifndef WINCH_LINE_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH
`define WINCH_LINE_VELOCITY_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define WLVC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("wlvc assertion failed");
`define WLVC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("wlvc assertion failed during or after reset");
`else
`define WLVC_ASSERT(lbl, prop)
`define WLVC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== src/wlvc_pkg.sv =====
`default_nettype none
package wlvc_pkg;
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_SQRT = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    // request to the shared iterative unit
    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [63:0] a;
        logic [32:0] b;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;
endpackage
`default_nettype wire

// ===== src/wlvc_iter_unit.sv =====
`default_nettype none
// Shared shift/add unit: serial multiply (32 steps), square root (32 steps),
// restoring divide (48 steps). One add/compare per cycle.
module wlvc_iter_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire wlvc_pkg::alu_req_t req,
    output wlvc_pkg::alu_stat_t    stat,
    output logic [63:0]            res
);
    logic        busy_reg, done_reg;
    logic [1:0]  op_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] acc_reg, a_reg;
    logic [32:0] b_reg;
    logic [35:0] rem_reg;
    logic [35:0] rem_sq, rem_dv, trial;
    logic [5:0]  last;

    assign rem_sq = {rem_reg[33:0], a_reg[63:62]};
    assign trial  = {2'b00, acc_reg[31:0], 2'b01};
    assign rem_dv = {rem_reg[34:0], a_reg[47]};
    assign last   = (op_reg == wlvc_pkg::OP_DIV) ? 6'd47 : 6'd31;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && !req.start && (cnt_reg == last);
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                case (op_reg)
                    wlvc_pkg::OP_MUL: begin
                        if (b_reg[0]) acc_reg <= acc_reg + a_reg;
                        a_reg <= {a_reg[62:0], 1'b0};
                        b_reg <= {1'b0, b_reg[32:1]};
                    end
                    wlvc_pkg::OP_SQRT: begin
                        if (rem_sq >= trial) begin
                            rem_reg <= rem_sq - trial;
                            acc_reg <= {acc_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sq;
                            acc_reg <= {acc_reg[62:0], 1'b0};
                        end
                        a_reg <= {a_reg[61:0], 2'b00};
                    end
                    wlvc_pkg::OP_DIV: begin
                        if (rem_dv >= {3'b000, b_reg}) begin
                            rem_reg <= rem_dv - {3'b000, b_reg};
                            acc_reg <= {acc_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= rem_dv;
                            acc_reg <= {acc_reg[62:0], 1'b0};
                        end
                        a_reg <= {a_reg[62:0], 1'b0};
                    end
                    default: ;
                endcase
                cnt_reg  <= cnt_reg + 6'd1;
                busy_reg <= (cnt_reg != last);
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = acc_reg;
endmodule
`default_nettype wire

// ===== src/winch_line_velocity_controller_unit.sv =====
`default_nettype none
// Each transaction runs through the shared serial unit in turn: 8 multiplies, one root
// and two divides (start register, steps, done pulse), then the finish step; in the
// deadband one divide and four multiplies are skipped. A new transaction is taken only
// once the sequencer is back in idle; input is taken again while a result waits, and the
// finish step holds while the previous result is not taken.
// Reset (aresetn, synchronous, low): registers to defaults, filter, stored length
// and last publish time to zero, output empty.
`include "winch_line_velocity_controller_unit_defines.svh"
module winch_line_velocity_controller_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // drone_x, drone_y, drone_z, anchor_x, anchor_y, anchor_z, spool_angle,
    // spool_speed (32 b each), time_us (48 b)
    input  wire logic [303:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // speed_command 32, tension_estimate 31, separation 31, length_change 32,
    // delta_x 32, delta_y 32, delta_z 32, 2 zero bits
    output logic [223:0]      m_tdata,
    // publish_tick
    output logic              m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam logic [3:0] S_IDLE = 4'd0, S_SQ0 = 4'd1, S_SQ1 = 4'd2, S_SQ2 = 4'd3,
                           S_ROOT = 4'd4, S_DIVT = 4'd5, S_DIVK = 4'd6, S_MULP = 4'd7,
                           S_MULD = 4'd8, S_MULW = 4'd9, S_MULR = 4'd10, S_TEN = 4'd11,
                           S_FIN = 4'd12;
    localparam logic [2:0] R_RADIUS = 3'd0, R_OFFSET = 3'd1, R_DEADBAND = 3'd2,
                           R_DAMP = 3'd3, R_WEIGHT = 3'd4, R_LIMIT = 3'd5,
                           R_TGAIN = 3'd6, R_INTERVAL = 3'd7;

    // configuration registers
    logic [30:0] radius_reg, offset_reg, deadband_reg, damp_reg, limit_reg, tgain_reg;
    logic [16:0] weight_reg;
    logic [31:0] interval_reg;

    // sequencer and datapath
    logic [3:0]  state_reg;
    logic signed [32:0] d_reg [3];
    logic        big_reg;
    logic [31:0] angle_reg, speed_in_reg;
    logic [47:0] time_reg;
    logic [63:0] sq_reg, p_reg;
    logic [30:0] sep_reg, eff_reg, ten_reg;
    logic signed [32:0] err_reg;
    logic [31:0] aerr_reg;
    logic signed [47:0] raw_reg;
    logic [31:0] fc_reg, speed_out_reg, stored_reg;
    logic [47:0] last_time_reg;
    logic        m_valid_reg, m_pub_reg;
    logic [223:0] m_data_reg;

    wlvc_pkg::alu_req_t  req_reg;
    wlvc_pkg::alu_stat_t alu_st;
    logic [63:0]         alu_res;

    wlvc_iter_unit u_iter (
        .aclk(aclk), .aresetn(aresetn), .req(req_reg), .stat(alu_st), .res(alu_res)
    );

    // input differences and magnitudes
    logic signed [32:0] d_c [3];
    logic [32:0]        mag_c [3];
    logic               big_c;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_c[i]   = $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]})
                     - $signed({s_tdata[32*i+127], s_tdata[32*i+96 +: 32]});
            mag_c[i] = d_c[i][32] ? 33'(-d_c[i]) : 33'(d_c[i]);
        end
        big_c = (mag_c[0] > {2'b00, wlvc_pkg::MAX31}) || (mag_c[1] > {2'b00, wlvc_pkg::MAX31})
             || (mag_c[2] > {2'b00, wlvc_pkg::MAX31});
    end

    logic [32:0] magr [3];
    always_comb begin
        for (int i = 0; i < 3; i++) magr[i] = d_reg[i][32] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
    end

    // separation and effective length from the root
    logic [30:0] sep_c, eff_c;
    assign sep_c = (big_reg || alu_res[31]) ? wlvc_pkg::MAX31 : alu_res[30:0];
    assign eff_c = (sep_c >= offset_reg) ? sep_c - offset_reg : 31'd0;

    // target angle and error from the quotient (zero radius gives all ones, saturates)
    logic [30:0]        target_c;
    logic signed [32:0] err_c;
    logic [31:0]        aerr_c;
    assign target_c = (alu_res[47:0] > {17'd0, wlvc_pkg::MAX31}) ? wlvc_pkg::MAX31
                                                                : alu_res[30:0];
    assign err_c  = $signed({2'b00, target_c}) - $signed({angle_reg[31], angle_reg});
    assign aerr_c = err_c[32] ? 32'(-err_c) : err_c[31:0];

    logic [16:0] w_eff;
    assign w_eff = weight_reg[16] ? 17'h10000 : weight_reg;

    logic signed [63:0] sum_c, mix_c;
    logic signed [47:0] v_c, lim_c;
    logic [31:0]        clamp_c;
    assign sum_c   = $signed(p_reg) - $signed(alu_res);
    assign mix_c   = $signed(p_reg) + $signed(alu_res);
    assign v_c     = mix_c[63:16];
    assign lim_c   = $signed({17'd0, limit_reg});
    assign clamp_c = (v_c > lim_c) ? lim_c[31:0] : ((v_c < -lim_c) ? 32'(-lim_c) : v_c[31:0]);

    logic        pub_c;
    logic [47:0] tdiff_c;
    logic [31:0] dlen_c;
    assign tdiff_c = time_reg - last_time_reg;
    assign pub_c   = (time_reg >= last_time_reg) && (tdiff_c > {16'd0, interval_reg});
    assign dlen_c  = {1'b0, eff_reg} - stored_reg;

    logic        load_out;
    assign load_out = (state_reg == S_FIN) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            req_reg.start <= 1'b0;
            m_valid_reg   <= 1'b0;
            fc_reg        <= '0;
            stored_reg    <= '0;
            last_time_reg <= '0;
        end else begin
            // drop the start pulse the cycle after a request; no step issues then
            if (req_reg.start) req_reg.start <= 1'b0;
            if (m_tready && !load_out) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    for (int i = 0; i < 3; i++) d_reg[i] <= d_c[i];
                    big_reg      <= big_c;
                    angle_reg    <= s_tdata[223:192];
                    speed_in_reg <= s_tdata[255:224];
                    time_reg     <= s_tdata[303:256];
                    sq_reg       <= '0;
                    req_reg      <= {1'b1, wlvc_pkg::OP_MUL, {31'd0, mag_c[0]},
                                     {1'b0, mag_c[0][31:0]}};
                    state_reg    <= S_SQ0;
                end
                S_SQ0: if (alu_st.done) begin
                    sq_reg    <= alu_res;
                    req_reg   <= {1'b1, wlvc_pkg::OP_MUL, {31'd0, magr[1]},
                                  {1'b0, magr[1][31:0]}};
                    state_reg <= S_SQ1;
                end
                S_SQ1: if (alu_st.done) begin
                    sq_reg    <= sq_reg + alu_res;
                    req_reg   <= {1'b1, wlvc_pkg::OP_MUL, {31'd0, magr[2]},
                                  {1'b0, magr[2][31:0]}};
                    state_reg <= S_SQ2;
                end
                S_SQ2: if (alu_st.done) begin
                    req_reg   <= {1'b1, wlvc_pkg::OP_SQRT, sq_reg + alu_res, 33'd0};
                    state_reg <= S_ROOT;
                end
                S_ROOT: if (alu_st.done) begin
                    sep_reg   <= sep_c;
                    eff_reg   <= eff_c;
                    req_reg   <= {1'b1, wlvc_pkg::OP_DIV, {17'd0, eff_c, 16'd0},
                                  {2'b00, radius_reg}};
                    state_reg <= S_DIVT;
                end
                S_DIVT: if (alu_st.done) begin
                    err_reg  <= err_c;
                    aerr_reg <= aerr_c;
                    if (aerr_c > {1'b0, deadband_reg}) begin
                        req_reg   <= {1'b1, wlvc_pkg::OP_DIV, {16'd0, aerr_c, 16'd0},
                                      {1'b0, aerr_c} + 33'h1_0000};
                        state_reg <= S_DIVK;
                    end else begin
                        // deadband: command zero, hold filter
                        speed_out_reg <= '0;
                        req_reg   <= {1'b1, wlvc_pkg::OP_MUL, {32'd0, aerr_c},
                                      {2'b00, tgain_reg}};
                        state_reg <= S_TEN;
                    end
                end
                S_DIVK: if (alu_st.done) begin
                    req_reg   <= {1'b1, wlvc_pkg::OP_MUL, 64'(err_reg),
                                  {16'd0, alu_res[16:0]}};
                    state_reg <= S_MULP;
                end
                S_MULP: if (alu_st.done) begin
                    p_reg     <= alu_res;
                    req_reg   <= {1'b1, wlvc_pkg::OP_MUL, 64'($signed(speed_in_reg)),
                                  {2'b00, damp_reg}};
                    state_reg <= S_MULD;
                end
                S_MULD: if (alu_st.done) begin
                    raw_reg   <= sum_c[63:16];
                    req_reg   <= {1'b1, wlvc_pkg::OP_MUL, 64'($signed(fc_reg)),
                                  {16'd0, w_eff}};
                    state_reg <= S_MULW;
                end
                S_MULW: if (alu_st.done) begin
                    p_reg     <= alu_res;
                    req_reg   <= {1'b1, wlvc_pkg::OP_MUL, 64'(raw_reg),
                                  {16'd0, 17'h10000 - w_eff}};
                    state_reg <= S_MULR;
                end
                S_MULR: if (alu_st.done) begin
                    fc_reg        <= clamp_c;
                    speed_out_reg <= clamp_c;
                    req_reg   <= {1'b1, wlvc_pkg::OP_MUL, {32'd0, aerr_reg},
                                  {2'b00, tgain_reg}};
                    state_reg <= S_TEN;
                end
                S_TEN: if (alu_st.done) begin
                    ten_reg   <= (alu_res[63:47] != 17'd0) ? wlvc_pkg::MAX31 : alu_res[46:16];
                    state_reg <= S_FIN;
                end
                S_FIN: if (load_out) begin
                    m_valid_reg <= 1'b1;
                    m_pub_reg   <= pub_c;
                    m_data_reg  <= {2'b00, d_reg[2][31:0], d_reg[1][31:0], d_reg[0][31:0],
                                    dlen_c, sep_reg, ten_reg, speed_out_reg};
                    if (pub_c) begin
                        last_time_reg <= time_reg;
                        stored_reg    <= {1'b0, eff_reg};
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_pub_reg;

    // configuration port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 31'd3277;
            offset_reg   <= 31'd3277;
            deadband_reg <= 31'd39322;
            damp_reg     <= 31'd3277;
            weight_reg   <= 17'd32768;
            limit_reg    <= 31'd193987;
            tgain_reg    <= 31'd3277;
            interval_reg <= 32'd10000;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                R_RADIUS:   radius_reg   <= pwdata[30:0];
                R_OFFSET:   offset_reg   <= pwdata[30:0];
                R_DEADBAND: deadband_reg <= pwdata[30:0];
                R_DAMP:     damp_reg     <= pwdata[30:0];
                R_WEIGHT:   weight_reg   <= pwdata[16:0];
                R_LIMIT:    limit_reg    <= pwdata[30:0];
                R_TGAIN:    tgain_reg    <= pwdata[30:0];
                R_INTERVAL: interval_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            R_RADIUS:   prdata = {1'b0, radius_reg};
            R_OFFSET:   prdata = {1'b0, offset_reg};
            R_DEADBAND: prdata = {1'b0, deadband_reg};
            R_DAMP:     prdata = {1'b0, damp_reg};
            R_WEIGHT:   prdata = {15'd0, weight_reg};
            R_LIMIT:    prdata = {1'b0, limit_reg};
            R_TGAIN:    prdata = {1'b0, tgain_reg};
            R_INTERVAL: prdata = interval_reg;
            default:    prdata = '0;
        endcase
    end

    // an accepted transaction closes the input until the result is registered
    `WLVC_ASSERT(a_take_once, (s_tvalid && s_tready) |=> !s_tready)
    // the shared unit is never left running while the sequencer is idle
    `WLVC_ASSERT(a_idle_unit, (state_reg == S_IDLE) |-> !alu_st.busy)
    // a new result only comes from the finish step
    `WLVC_ASSERT(a_out_src, $rose(m_valid_reg) |-> ($past(state_reg) == S_FIN))
    // the unit never starts while it still runs
    `WLVC_ASSERT(a_no_restart, !(req_reg.start && alu_st.busy))
endmodule
`default_nettype wire
